[rtl/cfhi_pkg.sv]
// ----------------------------------------------------------------------------
// cfhi_pkg
// Types and constants shared by the cuckoo filter key hash and index pipeline.
// ----------------------------------------------------------------------------
package cfhi_pkg;

   localparam int BUCKET_COUNT = 1024;

   localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;
   localparam logic [31:0] HASH_MUL  = 32'h5bd1e995;

   // only the low index bits of a product can reach the masked index
   localparam logic [9:0] HASH_MUL_LO = HASH_MUL[9:0];
   localparam logic [9:0] IDX_MASK    = 10'((BUCKET_COUNT - 1) & 32'h3ff);

   localparam logic [3:0] KEY_LEN_MAX = 4'd8;

   typedef enum logic {
      FUNC_HASH = 1'b0,
      FUNC_ALT  = 1'b1
   } func_type;

   typedef struct packed {
      logic        func;
      logic [63:0] key_bytes;
      logic [3:0]  key_len;
      logic [9:0]  bucket_in;
      logic [7:0]  tag_in;
   } req_type;

   typedef struct packed {
      logic        key_error;
      logic [31:0] hash_value;
      logic [7:0]  fingerprint;
      logic [9:0]  primary_index;
      logic [9:0]  alternate_index;
   } rsp_type;

   // side information that travels with a beat down the pipeline
   typedef struct packed {
      logic        func;
      logic        key_error;
      logic [3:0]  key_len;
      logic [9:0]  bucket;
      logic [7:0]  tag;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] h_word;
      logic [31:0] h_mul;
      logic [31:0] k_hi;
      logic [31:0] h_short;
   } mix_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] hash;
   } fin_type;

endpackage

[rtl/cuckoo_filter_key_hash_index.sv]
// ----------------------------------------------------------------------------
// cuckoo_filter_key_hash_index
// Key hash and bucket index unit for a cuckoo filter.
// ----------------------------------------------------------------------------
// A beat is taken at every clock edge with start high; busy never rises, so a
// new key or alternate-bucket request may enter every cycle. Each beat comes
// out on rsp_data with rsp_valid high for one cycle, in the order the beats
// went in. Each beat passes through the chain of four dependent multiplies of
// the hash (two on the key words, one on the trailing word, one in the final
// mix), each in a register stage of its own, then through the closing shift
// stage of the final mix and the result register.
// rsp_valid cannot be held off.
module cuckoo_filter_key_hash_index (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cfhi_pkg::req_type req_data,
   output logic              rsp_valid,
   output cfhi_pkg::rsp_type rsp_data
);

   logic              mix_valid;
   cfhi_pkg::mix_type mix_data;
   logic              fin_valid;
   cfhi_pkg::fin_type fin_data;

   assign busy = 1'b0;

   cfhi_key_mix u_key_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_data   (req_data),
      .out_valid (mix_valid),
      .out_data  (mix_data)
   );

   cfhi_finalize u_finalize (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_data   (mix_data),
      .out_valid (fin_valid),
      .out_data  (fin_data)
   );

   cfhi_index u_index (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fin_valid),
      .in_data   (fin_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

[rtl/cfhi_key_mix.sv]
// ----------------------------------------------------------------------------
// cfhi_key_mix
// Three register stages of the word and tail mixing of the key hash.
// ----------------------------------------------------------------------------
module cfhi_key_mix (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cfhi_pkg::req_type in_data,
   output logic             out_valid,
   output cfhi_pkg::mix_type out_data
);

   logic [3:0]        len_sat;
   logic [31:0]       tail_mask;
   logic [31:0]       seed_mix;
   cfhi_pkg::ctl_type ctl_in;

   // stage 1
   logic              s1_valid_ff;
   cfhi_pkg::ctl_type s1_ctl_ff;
   logic [31:0]       s1_p_ff, s1_q_ff, s1_hs_ff, s1_ht_ff, s1_tail_ff;
   // stage 2
   logic              s2_valid_ff;
   cfhi_pkg::ctl_type s2_ctl_ff;
   logic [31:0]       s2_ka_ff, s2_kb_ff, s2_hs_ff, s2_ht_ff, s2_tail_ff;
   // stage 3
   logic              s3_valid_ff;
   cfhi_pkg::mix_type s3_data_ff;
   logic [31:0]       h_word_in, h_tail_in;

   always_comb begin
      len_sat = (in_data.key_len > cfhi_pkg::KEY_LEN_MAX) ? cfhi_pkg::KEY_LEN_MAX
                                                           : in_data.key_len;
      case (len_sat[1:0])
         2'd1:    tail_mask = 32'h0000_00ff;
         2'd2:    tail_mask = 32'h0000_ffff;
         2'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = 32'h0000_0000;
      endcase
      seed_mix         = cfhi_pkg::HASH_SEED ^ {28'd0, len_sat};
      ctl_in.func      = in_data.func;
      ctl_in.key_error = (in_data.func == cfhi_pkg::FUNC_HASH) && (in_data.key_len == 4'd0);
      ctl_in.key_len   = len_sat;
      ctl_in.bucket    = in_data.bucket_in;
      ctl_in.tag       = in_data.tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_ctl_ff  <= ctl_in;
      s1_p_ff    <= in_data.key_bytes[31:0] * cfhi_pkg::HASH_MUL;
      s1_q_ff    <= in_data.key_bytes[63:32] * cfhi_pkg::HASH_MUL;
      s1_hs_ff   <= seed_mix * cfhi_pkg::HASH_MUL;
      // short key: seed and tail mixed at once
      s1_ht_ff   <= (seed_mix ^ (in_data.key_bytes[31:0] & tail_mask)) * cfhi_pkg::HASH_MUL;
      s1_tail_ff <= in_data.key_bytes[63:32] & tail_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ctl_ff  <= s1_ctl_ff;
      s2_ka_ff   <= (s1_p_ff ^ (s1_p_ff >> 24)) * cfhi_pkg::HASH_MUL;
      s2_kb_ff   <= (s1_q_ff ^ (s1_q_ff >> 24)) * cfhi_pkg::HASH_MUL;
      s2_hs_ff   <= s1_hs_ff;
      s2_ht_ff   <= s1_ht_ff;
      s2_tail_ff <= s1_tail_ff;
   end

   always_comb begin
      h_word_in = s2_hs_ff ^ s2_ka_ff;
      // tail after one full word for lengths five to seven
      if (s2_ctl_ff.key_len[3:2] == 2'b01 && s2_ctl_ff.key_len[1:0] != 2'd0) begin
         h_tail_in = h_word_in ^ s2_tail_ff;
      end else begin
         h_tail_in = h_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_data_ff.ctl     <= s2_ctl_ff;
      s3_data_ff.h_word  <= h_word_in;
      s3_data_ff.h_mul   <= h_tail_in * cfhi_pkg::HASH_MUL;
      s3_data_ff.k_hi    <= s2_kb_ff;
      s3_data_ff.h_short <= s2_ht_ff;
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

[rtl/cfhi_finalize.sv]
// ----------------------------------------------------------------------------
// cfhi_finalize
// Picks the mixed hash by key length and runs the final avalanche mix.
// ----------------------------------------------------------------------------
module cfhi_finalize (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cfhi_pkg::mix_type in_data,
   output logic             out_valid,
   output cfhi_pkg::fin_type out_data
);

   logic [31:0]       h_sel;
   logic [31:0]       h_mix;

   logic              s4_valid_ff;
   cfhi_pkg::ctl_type s4_ctl_ff;
   logic [31:0]       s4_g_ff;

   logic              s5_valid_ff;
   cfhi_pkg::fin_type s5_data_ff;

   always_comb begin
      if (in_data.ctl.key_len < 4'd4) begin
         h_sel = in_data.h_short;
      end else if (in_data.ctl.key_len == 4'd4) begin
         h_sel = in_data.h_word;
      end else if (in_data.ctl.key_len == cfhi_pkg::KEY_LEN_MAX) begin
         h_sel = in_data.h_mul ^ in_data.k_hi;
      end else begin
         h_sel = in_data.h_mul;
      end
      h_mix = h_sel ^ (h_sel >> 13);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= in_valid;
      end
      s4_ctl_ff <= in_data.ctl;
      s4_g_ff   <= h_mix * cfhi_pkg::HASH_MUL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_data_ff.ctl  <= s4_ctl_ff;
      s5_data_ff.hash <= s4_g_ff ^ (s4_g_ff >> 15);
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_data_ff;

endmodule

[rtl/cfhi_index.sv]
// ----------------------------------------------------------------------------
// cfhi_index
// Fingerprint, primary bucket and alternate bucket; registered result beat.
// ----------------------------------------------------------------------------
module cfhi_index (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cfhi_pkg::fin_type in_data,
   output logic             out_valid,
   output cfhi_pkg::rsp_type out_data
);

   logic [7:0]        fp;
   logic [9:0]        prim;
   logic [9:0]        bkt;
   logic [7:0]        tg;
   logic [9:0]        spread;
   cfhi_pkg::rsp_type rsp_in;

   logic              rsp_valid_ff;
   cfhi_pkg::rsp_type rsp_data_ff;

   always_comb begin
      fp   = (in_data.hash[7:0] == 8'd0) ? 8'd1 : in_data.hash[7:0];
      prim = in_data.hash[17:8] & cfhi_pkg::IDX_MASK;
      if (in_data.ctl.func == cfhi_pkg::FUNC_ALT) begin
         bkt = in_data.ctl.bucket;
         tg  = in_data.ctl.tag;
      end else begin
         bkt = prim;
         tg  = fp;
      end
      spread = {2'd0, tg} * cfhi_pkg::HASH_MUL_LO;

      rsp_in.key_error       = 1'b0;
      rsp_in.hash_value      = 32'd0;
      rsp_in.fingerprint     = 8'd0;
      rsp_in.primary_index   = 10'd0;
      rsp_in.alternate_index = (bkt ^ spread) & cfhi_pkg::IDX_MASK;
      if (in_data.ctl.func == cfhi_pkg::FUNC_HASH) begin
         if (in_data.ctl.key_error) begin
            rsp_in.key_error       = 1'b1;
            rsp_in.alternate_index = 10'd0;
         end else begin
            rsp_in.hash_value    = in_data.hash;
            rsp_in.fingerprint   = fp;
            rsp_in.primary_index = prim;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid;
      end
      rsp_data_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

endmodule
